// ===== src/shb4_pkg.sv =====
`default_nettype none

package shb4_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int MAX_DEGREE    = 4;

	// signed coefficient, millionths
	localparam int KW  = 23;
	// polynomial clamped before the coefficient product; anything outside saturates anyway
	localparam int PCW = 23;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_DEGREE = 2'd1,
		ST_BAD_ORDER  = 2'd2
	} status_t;

	// basis function index l*l + l + m
	typedef enum logic [4:0] {
		Y0_0,
		Y1_N1, Y1_0, Y1_P1,
		Y2_N2, Y2_N1, Y2_0, Y2_P1, Y2_P2,
		Y3_N3, Y3_N2, Y3_N1, Y3_0, Y3_P1, Y3_P2, Y3_P3,
		Y4_N4, Y4_N3, Y4_N2, Y4_N1, Y4_0, Y4_P1, Y4_P2, Y4_P3, Y4_P4
	} fn_t;

	typedef logic signed [KW-1:0] coef_t;

	// normalisation constant with the Condon-Shortley sign folded in
	function automatic coef_t coef_lookup(fn_t fn);
		coef_t k;
		unique case (fn)
			Y0_0:    k = coef_t'(282095);
			Y1_N1:   k = coef_t'(-488603);
			Y1_0:    k = coef_t'(488603);
			Y1_P1:   k = coef_t'(-488603);
			Y2_N2:   k = coef_t'(1092548);
			Y2_N1:   k = coef_t'(-1092548);
			Y2_0:    k = coef_t'(315392);
			Y2_P1:   k = coef_t'(-1092548);
			Y2_P2:   k = coef_t'(546274);
			Y3_N3:   k = coef_t'(-590044);
			Y3_N2:   k = coef_t'(2890611);
			Y3_N1:   k = coef_t'(-457046);
			Y3_0:    k = coef_t'(373176);
			Y3_P1:   k = coef_t'(-457046);
			Y3_P2:   k = coef_t'(1445306);
			Y3_P3:   k = coef_t'(-590044);
			Y4_N4:   k = coef_t'(2503343);
			Y4_N3:   k = coef_t'(-1770131);
			Y4_N2:   k = coef_t'(946175);
			Y4_N1:   k = coef_t'(-669047);
			Y4_0:    k = coef_t'(105786);
			Y4_P1:   k = coef_t'(-669047);
			Y4_P2:   k = coef_t'(473087);
			Y4_P3:   k = coef_t'(-1770131);
			Y4_P4:   k = coef_t'(625836);
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== src/sh_basis_eval_band4_unit.sv =====
// done and basis_value come straight from the stage 9 registers.
// Throughput: one evaluation per cycle; busy stays low, start may be held high.
// The receiver cannot stall, so the pipeline never holds.
// Nine register stages: products, operand select, second products, polynomial sum,
// coefficient product, rounding offset, three-step reciprocal divide by 10^6 and saturation.
// Reset (arst_n low) clears the stage valid bits; data registers are not reset.
`default_nettype none

module sh_basis_eval_band4_unit
	import shb4_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] dir_x,
	input  wire logic signed [15:0] dir_y,
	input  wire logic signed [15:0] dir_z,
	input  wire logic [3:0]         degree,
	input  wire logic signed [4:0]  order,
	output logic                    done,
	output logic signed [17:0]      basis_value,
	output logic [1:0]              status
);

	localparam int IW  = 16;
	localparam int RW  = 2 * IW;
	localparam int PW  = RW - FRAC_BITS;
	localparam int AW  = (PW + 1 > IW) ? PW + 1 : IW;
	localparam int BW  = (RW + 3 - FRAC_BITS > FRAC_BITS + 3) ? RW + 3 - FRAC_BITS
		: FRAC_BITS + 3;
	localparam int MW  = AW + BW;
	localparam int QW  = MW - FRAC_BITS;
	localparam int LW  = ((RW + 4 - FRAC_BITS > FRAC_BITS + 3) ? RW + 4 - FRAC_BITS
		: FRAC_BITS + 3) + 1;
	localparam int SW  = ((QW + 6 > LW) ? QW + 6 : LW) + 2;
	localparam int NW  = PCW + KW;
	localparam int XW  = NW + 2;
	localparam int OW  = 18;
	localparam int DSH = 6;
	localparam int AQW = 32;
	localparam int RCW = 19;
	localparam int QOW = OW;
	localparam int DIVISOR = 1000000;
	localparam int DIVQ    = DIVISOR >> DSH;
	localparam int OUT_LIM = 1 << (OW - 1);

	localparam logic signed [RW-1:0] HALF_R = RW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [MW-1:0] HALF_M = MW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [BW-1:0] ONE_B  = BW'(1) <<< FRAC_BITS;
	localparam logic signed [LW-1:0] ONE_L  = LW'(1) <<< FRAC_BITS;
	localparam logic signed [SW-1:0] PC_MAX = SW'((1 << (PCW - 1)) - 1);
	localparam logic signed [SW-1:0] PC_MIN = ~PC_MAX;
	// offset keeps the dividend non-negative: floor(n1 / 10^6) = value + OUT_LIM
	localparam logic signed [XW-1:0] BIAS    = XW'(64'(OUT_LIM) * DIVISOR + DIVISOR / 2);
	localparam logic signed [XW-1:0] SAT_LIM = XW'(64'(2 * OUT_LIM) * DIVISOR);
	localparam logic [RCW-1:0]       RECIP   = RCW'((64'd1 << AQW) / DIVQ);
	localparam logic [AQW-1:0]       DIVQ_W  = AQW'(DIVQ);

	// stage 1
	logic                  vld_s1;
	status_t               st_s1;
	fn_t                   fn_s1;
	logic signed [IW-1:0]  x_s1, y_s1, z_s1;
	logic signed [RW-1:0]  pxx_s1, pyy_s1, pzz_s1, pxy_s1, pyz_s1, pxz_s1;
	// stage 2
	logic                  vld_s2;
	status_t               st_s2;
	logic signed [AW-1:0]  a1_s2, a2_s2;
	logic signed [BW-1:0]  b1_s2, b2_s2;
	logic signed [LW-1:0]  lin_s2;
	logic                  m35_s2;
	coef_t                 k_s2;
	// stage 3
	logic                  vld_s3;
	status_t               st_s3;
	logic signed [MW-1:0]  pr1_s3, pr2_s3;
	logic signed [LW-1:0]  lin_s3;
	logic                  m35_s3;
	coef_t                 k_s3;
	// stage 4
	logic                  vld_s4;
	status_t               st_s4;
	logic signed [PCW-1:0] pc_s4;
	coef_t                 k_s4;
	// stage 5
	logic                  vld_s5;
	status_t               st_s5;
	logic signed [NW-1:0]  n_s5;
	// stage 6
	logic                  vld_s6;
	status_t               st_s6;
	logic [AQW-1:0]        a_s6;
	logic                  sat_hi_s6, sat_lo_s6;
	// stage 7
	logic                  vld_s7;
	status_t               st_s7;
	logic [AQW-1:0]        a_s7;
	logic [QOW-1:0]        qe_s7;
	logic                  sat_hi_s7, sat_lo_s7;
	// stage 8
	logic                  vld_s8;
	status_t               st_s8;
	logic [AQW-1:0]        a_s8;
	logic [AQW-1:0]        qm_s8;
	logic [QOW-1:0]        qe_s8;
	logic                  sat_hi_s8, sat_lo_s8;
	// stage 9 (output)
	logic                  vld_s9;
	status_t               st_s9;
	logic signed [OW-1:0]  val_s9;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	function automatic logic signed [PW-1:0] rnd_prod(logic signed [RW-1:0] v);
		logic signed [RW-1:0] t;
		t = v + HALF_R;
		return t[RW-1:FRAC_BITS];
	endfunction

	// stage 1: range checks, function index, first products
	status_t             st_d;
	fn_t                 fn_d;
	logic [4:0]          base_d;
	logic signed [5:0]   m_w, l_w;

	always_comb begin
		m_w = 6'(order);
		l_w = $signed({2'b00, degree});
		unique case (degree)
			4'd0:    base_d = 5'd0;
			4'd1:    base_d = 5'd2;
			4'd2:    base_d = 5'd6;
			4'd3:    base_d = 5'd12;
			4'd4:    base_d = 5'd20;
			default: base_d = 5'd0;
		endcase
		fn_d = fn_t'(base_d + 5'(order));
		if (degree > 4'(MAX_DEGREE))
			st_d = ST_BAD_DEGREE;
		else if (m_w > l_w || m_w < -l_w)
			st_d = ST_BAD_ORDER;
		else
			st_d = ST_OK;
	end

	always_ff @(posedge clk) begin
		st_s1  <= st_d;
		fn_s1  <= fn_d;
		x_s1   <= dir_x;
		y_s1   <= dir_y;
		z_s1   <= dir_z;
		pxx_s1 <= dir_x * dir_x;
		pyy_s1 <= dir_y * dir_y;
		pzz_s1 <= dir_z * dir_z;
		pxy_s1 <= dir_x * dir_y;
		pyz_s1 <= dir_y * dir_z;
		pxz_s1 <= dir_x * dir_z;
	end

	// stage 2: round the products, pick operands per function
	logic signed [PW-1:0] x2, y2, z2, xy, yz, xz;
	logic signed [BW-1:0] x2b, y2b, z2b, t_x2my2, t_3x2my2, t_x2m3y2, t_4z2, t_2z2_3;
	logic signed [BW-1:0] t_7z2, t_7z2m1, t_7z2m3;
	logic signed [LW-1:0] z2l, l_2z2;
	logic signed [AW-1:0] a1_d, a2_d;
	logic signed [BW-1:0] b1_d, b2_d;
	logic signed [LW-1:0] lin_d;
	logic                 m35_d;

	always_comb begin
		x2 = rnd_prod(pxx_s1);
		y2 = rnd_prod(pyy_s1);
		z2 = rnd_prod(pzz_s1);
		xy = rnd_prod(pxy_s1);
		yz = rnd_prod(pyz_s1);
		xz = rnd_prod(pxz_s1);

		x2b      = BW'(x2);
		y2b      = BW'(y2);
		z2b      = BW'(z2);
		t_x2my2  = x2b - y2b;
		t_3x2my2 = (x2b <<< 1) + x2b - y2b;
		t_x2m3y2 = x2b - (y2b <<< 1) - y2b;
		t_4z2    = (z2b <<< 2) - x2b - y2b;
		t_2z2_3  = (z2b <<< 1) - (x2b <<< 1) - x2b - (y2b <<< 1) - y2b;
		t_7z2    = (z2b <<< 3) - z2b;
		t_7z2m1  = t_7z2 - ONE_B;
		t_7z2m3  = t_7z2 - (ONE_B <<< 1) - ONE_B;
		z2l      = LW'(z2);
		l_2z2    = (z2l <<< 1) - LW'(x2) - LW'(y2);

		a1_d  = '0;
		b1_d  = '0;
		a2_d  = '0;
		b2_d  = '0;
		lin_d = '0;
		m35_d = 1'b0;
		unique case (fn_s1)
			Y0_0:  lin_d = ONE_L;
			Y1_N1: lin_d = LW'(y_s1);
			Y1_0:  lin_d = LW'(z_s1);
			Y1_P1: lin_d = LW'(x_s1);
			Y2_N2: lin_d = LW'(xy);
			Y2_N1: lin_d = LW'(yz);
			Y2_0:  lin_d = l_2z2;
			Y2_P1: lin_d = LW'(xz);
			Y2_P2: lin_d = LW'(x2) - LW'(y2);
			Y3_N3: begin a1_d = AW'(y_s1); b1_d = t_3x2my2; end
			Y3_N2: begin a1_d = AW'(xy);   b1_d = BW'(z_s1); end
			Y3_N1: begin a1_d = AW'(y_s1); b1_d = t_4z2;     end
			Y3_0:  begin a1_d = AW'(z_s1); b1_d = t_2z2_3;   end
			Y3_P1: begin a1_d = AW'(x_s1); b1_d = t_4z2;     end
			Y3_P2: begin a1_d = AW'(z_s1); b1_d = t_x2my2;   end
			Y3_P3: begin a1_d = AW'(x_s1); b1_d = t_x2m3y2;  end
			Y4_N4: begin a1_d = AW'(xy);   b1_d = t_x2my2;   end
			Y4_N3: begin a1_d = AW'(yz);   b1_d = t_3x2my2;  end
			Y4_N2: begin a1_d = AW'(xy);   b1_d = t_7z2m1;   end
			Y4_N1: begin a1_d = AW'(yz);   b1_d = t_7z2m3;   end
			Y4_0: begin
				// 35 z2^2 - 30 z2 + 3
				a1_d  = AW'(z2);
				b1_d  = z2b;
				m35_d = 1'b1;
				lin_d = (ONE_L <<< 1) + ONE_L - (z2l <<< 5) + (z2l <<< 1);
			end
			Y4_P1: begin a1_d = AW'(xz); b1_d = t_7z2m3; end
			Y4_P2: begin a1_d = AW'(x2) - AW'(y2); b1_d = t_7z2m1; end
			Y4_P3: begin a1_d = AW'(xz); b1_d = t_x2m3y2; end
			Y4_P4: begin
				a1_d = AW'(x2);
				b1_d = t_x2m3y2;
				a2_d = AW'(y2);
				b2_d = t_3x2my2;
			end
			default: lin_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		st_s2  <= st_s1;
		a1_s2  <= a1_d;
		b1_s2  <= b1_d;
		a2_s2  <= a2_d;
		b2_s2  <= b2_d;
		lin_s2 <= lin_d;
		m35_s2 <= m35_d;
		k_s2   <= coef_lookup(fn_s1);
	end

	// stage 3: second-level products
	always_ff @(posedge clk) begin
		st_s3  <= st_s2;
		pr1_s3 <= a1_s2 * b1_s2;
		pr2_s3 <= a2_s2 * b2_s2;
		lin_s3 <= lin_s2;
		m35_s3 <= m35_s2;
		k_s3   <= k_s2;
	end

	// stage 4: round, sum the polynomial, clamp
	logic signed [MW-1:0] t1, t2;
	logic signed [QW-1:0] q1, q2;
	logic signed [SW-1:0] q1e, p35, p_sum;
	logic signed [PCW-1:0] pc_d;

	always_comb begin
		t1    = pr1_s3 + HALF_M;
		t2    = pr2_s3 + HALF_M;
		q1    = t1[MW-1:FRAC_BITS];
		q2    = t2[MW-1:FRAC_BITS];
		q1e   = SW'(q1);
		p35   = (q1e <<< 5) + (q1e <<< 1) + q1e;
		p_sum = (m35_s3 ? p35 : q1e) - SW'(q2) + SW'(lin_s3);
		if (p_sum > PC_MAX)
			pc_d = PC_MAX[PCW-1:0];
		else if (p_sum < PC_MIN)
			pc_d = PC_MIN[PCW-1:0];
		else
			pc_d = p_sum[PCW-1:0];
	end

	always_ff @(posedge clk) begin
		st_s4 <= st_s3;
		pc_s4 <= pc_d;
		k_s4  <= k_s3;
	end

	// stage 5: coefficient product
	always_ff @(posedge clk) begin
		st_s5 <= st_s4;
		n_s5  <= pc_s4 * k_s4;
	end

	// stage 6: rounding offset and saturation detect
	logic signed [XW-1:0] n1;

	always_comb begin
		n1 = XW'(n_s5) + BIAS;
	end

	always_ff @(posedge clk) begin
		st_s6     <= st_s5;
		sat_hi_s6 <= n1 >= SAT_LIM;
		sat_lo_s6 <= n1[XW-1];
		a_s6      <= n1[DSH+AQW-1:DSH];
	end

	// stage 7: quotient estimate by reciprocal, low by at most one
	logic [AQW+RCW-1:0] rp;

	always_comb begin
		rp = a_s6 * RECIP;
	end

	always_ff @(posedge clk) begin
		st_s7     <= st_s6;
		a_s7      <= a_s6;
		qe_s7     <= rp[AQW+QOW-1:AQW];
		sat_hi_s7 <= sat_hi_s6;
		sat_lo_s7 <= sat_lo_s6;
	end

	// stage 8: back-multiply for the remainder
	always_ff @(posedge clk) begin
		st_s8     <= st_s7;
		a_s8      <= a_s7;
		qe_s8     <= qe_s7;
		qm_s8     <= AQW'(qe_s7) * DIVQ_W;
		sat_hi_s8 <= sat_hi_s7;
		sat_lo_s8 <= sat_lo_s7;
	end

	// stage 9: correct, remove offset, saturate
	logic [AQW-1:0]       rem;
	logic [QOW-1:0]       q_fin;
	logic signed [OW-1:0] val_d;

	always_comb begin
		rem   = a_s8 - qm_s8;
		q_fin = qe_s8 + QOW'(rem >= DIVQ_W);
		if (st_s8 != ST_OK)
			val_d = '0;
		else if (sat_hi_s8)
			val_d = {1'b0, {(OW - 1){1'b1}}};
		else if (sat_lo_s8)
			val_d = {1'b1, {(OW - 1){1'b0}}};
		else
			val_d = {~q_fin[QOW-1], q_fin[QOW-2:0]};
	end

	always_ff @(posedge clk) begin
		st_s9  <= st_s8;
		val_s9 <= val_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	assign done        = vld_s9;
	assign basis_value = val_s9;
	assign status      = st_s9;

`ifndef SYNTHESIS
	// every accepted beat is followed by done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##9 done)
		else $error("accepted beat did not complete after nine cycles");

	// error codes force a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> basis_value == '0)
		else $error("nonzero value with error status");

	// reciprocal estimate is never more than one short
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && st_s8 == ST_OK && !sat_hi_s8 && !sat_lo_s8 |-> rem < (DIVQ_W << 1))
		else $error("quotient estimate out of range");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import shb4_pkg::*;

	localparam int     FRAC        = FRAC_BITS_DEF;
	localparam int     N_RANDOM    = 1000;
	localparam int     TAIL_CYCLES = 20;
	localparam int     CYCLE_LIMIT = 200000;
	localparam longint COEF_SCALE  = 1000000;
	localparam longint VAL_MAX     = 131071;
	localparam longint VAL_MIN     = -131072;

	// directions for the directed beats: near-unit, axes, extremes of the port range
	localparam int DIR_X [6] = '{6554, 16384, 0, 0, -32768, 32767};
	localparam int DIR_Y [6] = '{-8192, 0, -16384, 0, 32767, 32767};
	localparam int DIR_Z [6] = '{12288, 0, 0, 16384, -32768, 32767};
	localparam int CORNER [5] = '{-16384, 0, 16384, -32768, 32767};

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [3:0]         l;
		logic signed [4:0]  m;
	} sh_query_t;

	typedef struct {
		logic signed [17:0] value;
		status_t            st;
	} basis_res_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [15:0] dir_x = '0;
	logic signed [15:0] dir_y = '0;
	logic signed [15:0] dir_z = '0;
	logic [3:0]         degree = '0;
	logic signed [4:0]  order = '0;
	logic               busy;
	logic               done;
	logic signed [17:0] basis_value;
	logic [1:0]         status;

	sh_query_t  query_q[$];
	basis_res_t basis_due[$];
	logic       feeding = 1'b0;
	int         n_items = 0;
	int         n_taken = 0;
	int         n_errors = 0;
	int         n_cycles = 0;
	int         burst_left = 1;
	int         gap_left = 0;

	sh_basis_eval_band4_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.dir_x       (dir_x),
		.dir_y       (dir_y),
		.dir_z       (dir_z),
		.degree      (degree),
		.order       (order),
		.done        (done),
		.basis_value (basis_value),
		.status      (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor((v + d/2) / d), i.e. round half up
	function automatic longint round_div(longint v, longint d);
		longint n;
		longint q;
		n = v + d / 2;
		q = n / d;
		if (n % d != 0 && n < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return round_div(a * b, longint'(1) << FRAC);
	endfunction

	function automatic basis_res_t eval_basis(sh_query_t q);
		basis_res_t r;
		longint x, y, z, l, m, one;
		longint x2, y2, z2, xy, yz, xz, p, k, v;
		x = longint'(q.x);
		y = longint'(q.y);
		z = longint'(q.z);
		l = longint'(q.l);
		m = longint'(q.m);
		r.value = '0;
		// degree is checked before order
		if (l > MAX_DEGREE) begin
			r.st = ST_BAD_DEGREE;
			return r;
		end
		if (m > l || m < -l) begin
			r.st = ST_BAD_ORDER;
			return r;
		end
		r.st = ST_OK;
		one = longint'(1) << FRAC;
		x2 = fx_mul(x, x);
		y2 = fx_mul(y, y);
		z2 = fx_mul(z, z);
		xy = fx_mul(x, y);
		yz = fx_mul(y, z);
		xz = fx_mul(x, z);
		p = 0;
		k = 0;
		case (fn_t'(5'(l * l + l + m)))
			Y0_0: begin p = one; k = 282095; end
			Y1_N1: begin p = y; k = -488603; end
			Y1_0: begin p = z; k = 488603; end
			Y1_P1: begin p = x; k = -488603; end
			Y2_N2: begin p = xy; k = 1092548; end
			Y2_N1: begin p = yz; k = -1092548; end
			Y2_0: begin p = 2 * z2 - x2 - y2; k = 315392; end
			Y2_P1: begin p = xz; k = -1092548; end
			Y2_P2: begin p = x2 - y2; k = 546274; end
			Y3_N3: begin p = fx_mul(y, 3 * x2 - y2); k = -590044; end
			Y3_N2: begin p = fx_mul(xy, z); k = 2890611; end
			Y3_N1: begin p = fx_mul(y, 4 * z2 - x2 - y2); k = -457046; end
			Y3_0: begin p = fx_mul(z, 2 * z2 - 3 * x2 - 3 * y2); k = 373176; end
			Y3_P1: begin p = fx_mul(x, 4 * z2 - x2 - y2); k = -457046; end
			Y3_P2: begin p = fx_mul(z, x2 - y2); k = 1445306; end
			Y3_P3: begin p = fx_mul(x, x2 - 3 * y2); k = -590044; end
			Y4_N4: begin p = fx_mul(xy, x2 - y2); k = 2503343; end
			Y4_N3: begin p = fx_mul(yz, 3 * x2 - y2); k = -1770131; end
			Y4_N2: begin p = fx_mul(xy, 7 * z2 - one); k = 946175; end
			Y4_N1: begin p = fx_mul(yz, 7 * z2 - 3 * one); k = -669047; end
			Y4_0: begin p = 35 * fx_mul(z2, z2) - 30 * z2 + 3 * one; k = 105786; end
			Y4_P1: begin p = fx_mul(xz, 7 * z2 - 3 * one); k = -669047; end
			Y4_P2: begin p = fx_mul(x2 - y2, 7 * z2 - one); k = 473087; end
			Y4_P3: begin p = fx_mul(xz, x2 - 3 * y2); k = -1770131; end
			Y4_P4: begin
				p = fx_mul(x2, x2 - 3 * y2) - fx_mul(y2, 3 * x2 - y2);
				k = 625836;
			end
			default: begin p = 0; k = 0; end
		endcase
		v = round_div(p * k, COEF_SCALE);
		if (v > VAL_MAX)
			v = VAL_MAX;
		if (v < VAL_MIN)
			v = VAL_MIN;
		r.value = 18'(v);
		return r;
	endfunction

	function automatic sh_query_t mk_query(int x, int y, int z, int l, int m);
		sh_query_t q;
		q.x = 16'(x);
		q.y = 16'(y);
		q.z = 16'(z);
		q.l = 4'(l);
		q.m = 5'(m);
		return q;
	endfunction

	function automatic int pick_component(int mode);
		if (mode == 0)
			return int'($urandom_range(0, 32768)) - 16384;
		if (mode == 1)
			return int'($urandom_range(0, 65535)) - 32768;
		return CORNER[3'($urandom_range(0, 4))];
	endfunction

	// driver: bursts of beats from query_q with random gaps; data ports carry noise when idle
	always @(posedge clk) begin : drive
		sh_query_t q;
		logic      take;
		take = start && !busy;
		if (take) begin
			q = mk_query(int'(dir_x), int'(dir_y), int'(dir_z), int'(degree), int'(order));
			basis_due.push_back(eval_basis(q));
			n_taken++;
		end
		if (!arst_n || !feeding) begin
			start <= 1'b0;
		end else if (start && !take) begin
			// beat held until taken
		end else if (gap_left == 0 && query_q.size() != 0) begin
			q = query_q.pop_front();
			start  <= 1'b1;
			dir_x  <= q.x;
			dir_y  <= q.y;
			dir_z  <= q.z;
			degree <= q.l;
			order  <= q.m;
			if (burst_left <= 1) begin
				gap_left   = $urandom_range(0, 8);
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
					$urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end else begin
			start  <= 1'b0;
			dir_x  <= 16'($urandom);
			dir_y  <= 16'($urandom);
			dir_z  <= 16'($urandom);
			degree <= 4'($urandom);
			order  <= 5'($urandom);
			if (gap_left > 0)
				gap_left--;
		end
	end

	always @(posedge clk) begin : watch
		basis_res_t want;
		if (arst_n && done) begin
			if (basis_due.size() == 0) begin
				$display("%0t: result with nothing expected: value %0d status %0d",
					$time, basis_value, status);
				n_errors++;
			end else begin
				want = basis_due.pop_front();
				if (basis_value !== want.value) begin
					$display("%0t: basis_value expected %0d actual %0d",
						$time, want.value, basis_value);
					n_errors++;
				end
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.st, status);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("[sh_basis_eval_band4_unit] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		sh_query_t q;
		int        l, m, sel;
		real       a, b, c, nrm;

		// all 25 functions, directions cycling through near-unit, axes and extremes
		for (int i = 0; i < 25; i++) begin
			l = 0;
			while ((l + 1) * (l + 1) <= i)
				l++;
			m = i - l * l - l;
			query_q.push_back(mk_query(DIR_X[3'(i % 6)], DIR_Y[3'(i % 6)],
				DIR_Z[3'(i % 6)], l, m));
		end
		// unsupported degree, degree taking priority over order, orders past the band
		query_q.push_back(mk_query(6554, -8192, 12288, 5, 0));
		query_q.push_back(mk_query(-32768, 32767, 0, 15, -16));
		query_q.push_back(mk_query(6554, -8192, 12288, 2, 3));
		query_q.push_back(mk_query(0, 0, 16384, 0, 15));
		query_q.push_back(mk_query(16384, 0, 0, 4, -16));

		for (int i = 0; i < N_RANDOM; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				l = $urandom_range(0, 4);
				m = int'($urandom_range(0, 2 * l)) - l;
			end else if (sel < 90) begin
				l = $urandom_range(5, 15);
				m = int'($urandom_range(0, 31)) - 16;
			end else begin
				l = $urandom_range(0, 4);
				if ($urandom_range(0, 1) == 0)
					m = l + 1 + int'($urandom_range(0, 14 - l));
				else
					m = -(l + 1 + int'($urandom_range(0, 15 - l)));
			end
			sel = $urandom_range(0, 9);
			if (sel < 5) begin
				a = real'($urandom_range(0, 65536)) - 32768.0;
				b = real'($urandom_range(0, 65536)) - 32768.0;
				c = real'($urandom_range(0, 65536)) - 32768.0;
				nrm = $sqrt(a * a + b * b + c * c);
				if (nrm < 1.0) begin
					a = 0.0;
					b = 0.0;
					c = 1.0;
					nrm = 1.0;
				end
				q = mk_query($rtoi(a / nrm * 16384.0), $rtoi(b / nrm * 16384.0),
					$rtoi(c / nrm * 16384.0), l, m);
			end else begin
				// 0: inside Q1.14 range, 1: whole port range, 2: corner values
				sel = (sel < 8) ? 0 : sel - 7;
				q = mk_query(pick_component(sel), pick_component(sel),
					pick_component(sel), l, m);
			end
			query_q.push_back(q);
		end
		n_items = query_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		feeding <= 1'b1;
		while (n_taken != n_items)
			@(posedge clk);
		while (basis_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0 && basis_due.size() == 0)
			$display("[sh_basis_eval_band4_unit] OK");
		else
			$display("[sh_basis_eval_band4_unit] ERROR");
		$finish;
	end

endmodule
